/* hdl/dabpf_pkg.sv */
// Shared types, constants and the microprogram ROM of the packet framer.
// Used by dabpf_sequencer and dab_packet_framer; depends on nothing else.
package dabpf_pkg;

    localparam int unsigned PC_W       = 3;
    localparam int unsigned MAX_USEFUL = 91;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h1021;

    // useful-byte limits per size code (total size minus header and CRC)
    localparam logic [6:0] LIM_24 = 7'd19;
    localparam logic [6:0] LIM_48 = 7'd43;
    localparam logic [6:0] LIM_72 = 7'd67;
    localparam logic [6:0] LIM_96 = 7'd91;

    // byte source selected by a control word
    typedef enum logic [2:0] {
        SRC_NONE,
        SRC_H0,
        SRC_H1,
        SRC_H2,
        SRC_DATA,
        SRC_ZERO,
        SRC_CRC_HI,
        SRC_CRC_LO
    } src_t;

    // sequencing condition of a control word
    typedef enum logic [2:0] {
        C_ACCEPT,
        C_NEXT,
        C_IF_MORE,
        C_PAD,
        C_JUMP
    } cond_t;

    typedef struct packed {
        src_t            src;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ucode_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic drop;
        logic need_hdr;
        logic emit_ok;
        logic more;
        logic pad_zero;
    } status_t;

    localparam logic [PC_W-1:0] PC_FETCH = 3'd0;
    localparam logic [PC_W-1:0] PC_DATA  = 3'd4;

    // microprogram: one control word per step
    function automatic ucode_t rom_fetch(input logic [PC_W-1:0] pc);
        ucode_t cw;
        unique case (pc)
            3'd0: cw = '{src: SRC_NONE,   cond: C_ACCEPT,  target: PC_DATA};
            3'd1: cw = '{src: SRC_H0,     cond: C_NEXT,    target: PC_FETCH};
            3'd2: cw = '{src: SRC_H1,     cond: C_NEXT,    target: PC_FETCH};
            3'd3: cw = '{src: SRC_H2,     cond: C_NEXT,    target: PC_FETCH};
            3'd4: cw = '{src: SRC_DATA,   cond: C_IF_MORE, target: PC_FETCH};
            3'd5: cw = '{src: SRC_ZERO,   cond: C_PAD,     target: PC_FETCH};
            3'd6: cw = '{src: SRC_CRC_HI, cond: C_NEXT,    target: PC_FETCH};
            3'd7: cw = '{src: SRC_CRC_LO, cond: C_JUMP,    target: PC_FETCH};
            default: cw = '{src: SRC_NONE, cond: C_ACCEPT, target: PC_DATA};
        endcase
        return cw;
    endfunction

    // CRC-16, polynomial 0x1021, one byte MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* hdl/dabpf_sequencer.sv */
// Microcode sequencer: step counter, control ROM and jump logic.
// Depends on dabpf_pkg.
module dabpf_sequencer
(
    input  logic               clk,
    input  logic               rst_n,
    input  dabpf_pkg::status_t st,
    output dabpf_pkg::ucode_t  cw,
    output logic               fire
);

    logic [dabpf_pkg::PC_W-1:0] pc_reg;
    logic [dabpf_pkg::PC_W-1:0] pc_next;
    logic [dabpf_pkg::PC_W-1:0] pc_inc;

    assign cw     = dabpf_pkg::rom_fetch(pc_reg);
    assign pc_inc = pc_reg + 1'b1;

    // step strobe and next step
    always_comb
    begin
        fire    = 1'b0;
        pc_next = pc_reg;
        unique case (cw.cond)
            dabpf_pkg::C_ACCEPT:
            begin
                fire = st.in_valid;
                if (st.in_valid && !st.drop)
                    pc_next = st.need_hdr ? pc_inc : cw.target;
            end
            dabpf_pkg::C_NEXT:
            begin
                fire = st.emit_ok;
                if (st.emit_ok)
                    pc_next = pc_inc;
            end
            dabpf_pkg::C_IF_MORE:
            begin
                fire = st.emit_ok;
                if (st.emit_ok)
                    pc_next = st.more ? cw.target : pc_inc;
            end
            dabpf_pkg::C_PAD:
            begin
                // loop here until the padding count runs out
                if (st.pad_zero)
                    pc_next = pc_inc;
                else
                    fire = st.emit_ok;
            end
            dabpf_pkg::C_JUMP:
            begin
                fire = st.emit_ok;
                if (st.emit_ok)
                    pc_next = cw.target;
            end
            default:
            begin
                fire    = 1'b0;
                pc_next = dabpf_pkg::PC_FETCH;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= dabpf_pkg::PC_FETCH;
        else
            pc_reg <= pc_next;
    end

endmodule

/* hdl/dab_packet_framer.sv */
// Packet-mode framer top level: datapath, output register and sequencer.
// Each result byte appears on the output in the cycle after its step runs.
// Each data byte takes an accept step and a data step; opening a packet adds 3
// header steps, closing one adds a step per padding byte, one more, and 2 CRC
// steps. The microprogram emits at most one byte per cycle; an emitting step waits while the output is held.
// Reset (asynchronous, active low) clears all control state; CRC starts at all ones.
module dab_packet_framer
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [9:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic [15:0] group_length,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] packet_byte,
    output logic       packet_end,
    output logic       group_end
);

    dabpf_pkg::ucode_t  cw;
    dabpf_pkg::status_t st;
    logic               fire;

    logic [9:0]  addr_reg;
    logic [7:0]  data_reg,    data_next;
    logic [15:0] gbl_reg,     gbl_next;
    logic [6:0]  useful_reg,  useful_next;
    logic [1:0]  size_reg,    size_next;
    logic [4:0]  pad_reg,     pad_next;
    logic [1:0]  cont_reg,    cont_next;
    logic        first_reg,   first_next;
    logic [15:0] crc_reg,     crc_next;
    logic        ovalid_reg,  ovalid_next;
    logic [7:0]  obyte_reg,   obyte_next;
    logic        opend_reg,   opend_next;
    logic        ogend_reg,   ogend_next;

    logic [6:0]  hdr_useful;
    logic        hdr_last;
    logic [1:0]  hdr_size;
    logic [6:0]  hdr_lim;
    logic [6:0]  hdr_pad;
    logic [7:0]  byte_sel;
    logic        emit;
    logic        crc_feed;

    // status to the sequencer
    assign in_ready    = (cw.cond == dabpf_pkg::C_ACCEPT);
    assign st.in_valid = in_valid;
    assign st.drop     = (useful_reg == '0) && (gbl_reg == '0) && (group_length == '0);
    assign st.need_hdr = (useful_reg == '0);
    assign st.emit_ok  = !ovalid_reg || out_ready;
    assign st.more     = (useful_reg != 7'd1);
    assign st.pad_zero = (pad_reg == '0);

    dabpf_sequencer u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cw    (cw),
        .fire  (fire)
    );

    // header of the packet about to open
    always_comb
    begin
        hdr_last   = (gbl_reg <= 16'(dabpf_pkg::MAX_USEFUL));
        hdr_useful = hdr_last ? gbl_reg[6:0] : 7'(dabpf_pkg::MAX_USEFUL);
        if (hdr_useful <= dabpf_pkg::LIM_24)
        begin
            hdr_size = 2'd0;
            hdr_lim  = dabpf_pkg::LIM_24;
        end
        else if (hdr_useful <= dabpf_pkg::LIM_48)
        begin
            hdr_size = 2'd1;
            hdr_lim  = dabpf_pkg::LIM_48;
        end
        else if (hdr_useful <= dabpf_pkg::LIM_72)
        begin
            hdr_size = 2'd2;
            hdr_lim  = dabpf_pkg::LIM_72;
        end
        else
        begin
            hdr_size = 2'd3;
            hdr_lim  = dabpf_pkg::LIM_96;
        end
        hdr_pad = hdr_lim - hdr_useful;
    end

    // byte source
    always_comb
    begin
        case (cw.src)
            dabpf_pkg::SRC_H0:     byte_sel = {hdr_size, cont_reg, first_reg, hdr_last,
                                               addr_reg[9:8]};
            dabpf_pkg::SRC_H1:     byte_sel = addr_reg[7:0];
            dabpf_pkg::SRC_H2:     byte_sel = {1'b0, useful_reg};
            dabpf_pkg::SRC_DATA:   byte_sel = data_reg;
            dabpf_pkg::SRC_CRC_HI: byte_sel = ~crc_reg[15:8];
            dabpf_pkg::SRC_CRC_LO: byte_sel = ~crc_reg[7:0];
            default:               byte_sel = 8'h00;
        endcase
    end

    assign emit     = fire && (cw.src != dabpf_pkg::SRC_NONE);
    assign crc_feed = emit && (cw.src != dabpf_pkg::SRC_CRC_HI)
                           && (cw.src != dabpf_pkg::SRC_CRC_LO);

    // datapath next state
    always_comb
    begin
        data_next   = data_reg;
        gbl_next    = gbl_reg;
        useful_next = useful_reg;
        size_next   = size_reg;
        pad_next    = pad_reg;
        cont_next   = cont_reg;
        first_next  = first_reg;
        crc_next    = crc_reg;

        if (fire)
        begin
            case (cw.src)
                dabpf_pkg::SRC_NONE:
                begin
                    // transaction accepted: take the byte, open a group if due
                    data_next = data_byte;
                    if (useful_reg == '0 && gbl_reg == '0 && group_length != '0)
                    begin
                        gbl_next   = group_length;
                        first_next = 1'b1;
                    end
                end
                dabpf_pkg::SRC_H0:
                begin
                    useful_next = hdr_useful;
                    size_next   = hdr_size;
                    pad_next    = hdr_pad[4:0];
                    cont_next   = cont_reg + 2'd1;
                    first_next  = 1'b0;
                end
                dabpf_pkg::SRC_DATA:
                begin
                    useful_next = useful_reg - 7'd1;
                    gbl_next    = gbl_reg - 16'd1;
                end
                dabpf_pkg::SRC_ZERO:
                begin
                    pad_next = pad_reg - 5'd1;
                end
                default:
                begin
                    pad_next = pad_reg;
                end
            endcase
        end

        // CRC restarts with the first header byte
        if (crc_feed)
            crc_next = dabpf_pkg::crc_byte((cw.src == dabpf_pkg::SRC_H0) ?
                                           dabpf_pkg::CRC_INIT : crc_reg, byte_sel);
    end

    // output register
    always_comb
    begin
        ovalid_next = ovalid_reg;
        obyte_next  = obyte_reg;
        opend_next  = opend_reg;
        ogend_next  = ogend_reg;
        if (emit)
        begin
            ovalid_next = 1'b1;
            obyte_next  = byte_sel;
            opend_next  = (cw.src == dabpf_pkg::SRC_CRC_LO);
            ogend_next  = (cw.src == dabpf_pkg::SRC_CRC_LO) && (gbl_reg == '0);
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg   <= '0;
            gbl_reg    <= '0;
            useful_reg <= '0;
            size_reg   <= '0;
            pad_reg    <= '0;
            cont_reg   <= '0;
            first_reg  <= 1'b0;
            crc_reg    <= dabpf_pkg::CRC_INIT;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                addr_reg <= cfg_wr_data;
            gbl_reg    <= gbl_next;
            useful_reg <= useful_next;
            size_reg   <= size_next;
            pad_reg    <= pad_next;
            cont_reg   <= cont_next;
            first_reg  <= first_next;
            crc_reg    <= crc_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        obyte_reg <= obyte_next;
        opend_reg <= opend_next;
        ogend_reg <= ogend_next;
    end

    assign out_valid   = ovalid_reg;
    assign packet_byte = obyte_reg;
    assign packet_end  = opend_reg;
    assign group_end   = ogend_reg;

    // never more useful bytes than a packet holds
    a_useful_max: assert property (@(posedge clk) disable iff (!rst_n)
        useful_reg <= 7'(dabpf_pkg::MAX_USEFUL))
        else $error("useful count out of range");

    // a packet closes only once all its data and padding are out
    a_close: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && cw.src == dabpf_pkg::SRC_CRC_LO) |-> (useful_reg == '0 && pad_reg == '0))
        else $error("packet closed early");

    // group end only marks a packet end
    a_gend: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && group_end) |-> packet_end)
        else $error("group end without packet end");

    // the size code of an open packet matches what its header announced
    a_size: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && cw.src == dabpf_pkg::SRC_H0) |=> (size_reg == $past(hdr_size)))
        else $error("size code not held");

endmodule
